// File: hw/rtl/sal_pkg.sv
// Shared types and constants for the shifting array list.
package sal_pkg;

    localparam int LIST_CAPACITY = 32;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 2;
    localparam int POS_W         = 5;
    localparam int OUT_IDX_W     = 6;
    localparam int OUT_CNT_W     = 6;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_APPEND = 2'd1,
        K_REMOVE = 2'd2,
        K_SEARCH = 2'd3
    } t_kind;

    typedef struct packed {
        logic take_value;
        logic take_left;
        logic take_right;
        logic sample;
        logic live;
    } t_cell_ctl;

endpackage

// File: hw/rtl/shifting_array_list_top.sv
// Top level of the shifting array list: a row of entry cells and the request control.
// Insert, append and remove finish at the accepting edge, which also registers their result.
// Search samples all cells at the accepting edge; the last-match encoder then runs in S_FIND
// and its result is registered on leaving S_FIND, which blocks new requests meanwhile.
// A new request is taken every cycle for insert, append and remove unless i_ready stalls a result.
// Synchronous active-low reset empties the list and drops any pending result.
module shifting_array_list_top
    import sal_pkg::*;
#(
    parameter int CAPACITY = LIST_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_ok,
    output logic signed [OUT_IDX_W-1:0] o_found_index,
    output logic [OUT_CNT_W-1:0]        o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIND = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic          r_ok, n_ok;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_idx, n_idx;

    logic          accept;
    logic          full;
    logic          pos_ok;
    logic          do_insert, do_append, do_remove, do_search;
    logic [PW-1:0] pos_ext, cnt_ext;
    logic [CAPACITY-1:0] match;
    logic [DATA_W-1:0]   entry [CAPACITY];
    logic [IW-1:0]       enc_idx;
    logic [CW+OUT_CNT_W-1:0] cnt_wide;
    logic [IW+OUT_IDX_W-1:0] idx_wide;

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CW'(CAPACITY));
    assign pos_ext = PW'(i_position);
    assign cnt_ext = PW'(r_count);
    assign pos_ok  = pos_ext < cnt_ext;

    always_comb begin
        do_insert = 1'b0;
        do_append = 1'b0;
        do_remove = 1'b0;
        do_search = 1'b0;
        unique case (t_kind'(i_kind))
            K_INSERT: do_insert = accept && !full && pos_ok;
            K_APPEND: do_append = accept && !full;
            K_REMOVE: do_remove = accept && pos_ok;
            K_SEARCH: do_search = accept;
            default:  do_search = 1'b0;
        endcase
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl        ctl;
        logic [DATA_W-1:0] left_d, right_d;
        logic [PW-1:0]     my_idx;

        assign my_idx = PW'(gi);
        assign ctl.take_value = (do_insert && (my_idx == pos_ext))
                             || (do_append && (my_idx == cnt_ext));
        assign ctl.take_left  = do_insert && (my_idx > pos_ext);
        assign ctl.take_right = do_remove && (my_idx >= pos_ext) && (gi < CAPACITY - 1);
        assign ctl.sample     = do_search;
        assign ctl.live       = my_idx < cnt_ext;

        if (gi == 0) begin : g_first
            assign left_d = entry[gi];
        end else begin : g_mid
            assign left_d = entry[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right_d = entry[gi];
        end else begin : g_inner
            assign right_d = entry[gi+1];
        end

        sal_cell #(
            .W (DATA_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_entry (entry[gi]),
            .o_match (match[gi])
        );
    end

    always_comb begin
        enc_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match[i]) begin
                enc_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_hit       = r_hit;
        n_idx       = r_idx;
        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (do_search) begin
                        n_state = S_FIND;
                    end else begin
                        n_out_valid = 1'b1;
                        n_hit       = 1'b0;
                        n_ok        = do_insert || do_append || do_remove;
                        if (do_insert || do_append) begin
                            n_count = r_count + CW'(1);
                        end else if (do_remove) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            S_FIND: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_ok        = |match;
                n_hit       = |match;
                n_idx       = enc_idx;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ok  <= n_ok;
        r_hit <= n_hit;
        r_idx <= n_idx;
    end

    assign cnt_wide      = (CW + OUT_CNT_W)'(r_count);
    assign idx_wide      = (IW + OUT_IDX_W)'(r_idx);
    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_count       = cnt_wide[OUT_CNT_W-1:0];
    assign o_found_index = r_hit ? idx_wide[OUT_IDX_W-1:0] : {OUT_IDX_W{1'b1}};

endmodule

// File: hw/rtl/sal_cell.sv
// One list cell: holds an entry, shifts with its neighbors and compares on search.
module sal_cell
    import sal_pkg::*;
#(
    parameter int W = DATA_W
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic [W-1:0] i_value,
    input  logic [W-1:0] i_left,
    input  logic [W-1:0] i_right,
    output logic [W-1:0] o_entry,
    output logic         o_match
);

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;
    logic         r_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.take_value) begin
            n_entry = i_value;
        end else if (i_ctl.take_left) begin
            n_entry = i_left;
        end else if (i_ctl.take_right) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.sample) begin
            r_match <= i_ctl.live && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// File: verif/tb_shifting_array_list_top.sv
// Testbench for the shifting array list: random and directed requests checked against a predictor.
module tb_shifting_array_list_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sal_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RAND_REQS   = 1700;

    typedef enum int {
        TREND_MIX,
        TREND_GROW,
        TREND_SHRINK
    } t_trend;

    typedef struct packed {
        bit                         hold;
        t_kind                      kind;
        logic [POS_W-1:0]           pos;
        logic signed [DATA_W-1:0]   val;
        int unsigned                send_pct;
        int unsigned                recv_pct;
    } t_list_req;

    typedef struct packed {
        logic                        ok;
        logic signed [OUT_IDX_W-1:0] found_index;
        logic [OUT_CNT_W-1:0]        count;
    } t_list_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [KIND_W-1:0]           i_kind = K_INSERT;
    logic [POS_W-1:0]            i_position = '0;
    logic signed [DATA_W-1:0]    i_value = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic                        o_ok;
    logic signed [OUT_IDX_W-1:0] o_found_index;
    logic [OUT_CNT_W-1:0]        o_count;

    t_list_req                   req_backlog[$];
    t_list_reply                 due_replies[$];
    logic signed [DATA_W-1:0]    plan_vals[$];
    logic signed [DATA_W-1:0]    list_mem[LIST_CAPACITY];
    int                          list_len = 0;
    int                          reqs_planned = 0;
    int                          reqs_accepted = 0;
    int                          mismatches = 0;
    int                          quiet_cycles = 0;
    bit                          req_taken = 1'b0;
    int unsigned                 send_idle_pct = 0;
    int unsigned                 recv_stall_pct = 0;

    shifting_array_list_top #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_ok(o_ok),
        .o_found_index(o_found_index),
        .o_count(o_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_list_reply apply_list_op(t_kind kind, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
        t_list_reply r;
        int n;
        int p;
        p = pos;
        r.ok = 1'b0;
        r.found_index = '1;
        case (kind)
            K_INSERT: begin
                if (list_len < LIST_CAPACITY && p < list_len) begin
                    for (n = list_len; n > p; n--)
                        list_mem[n] = list_mem[n-1];
                    list_mem[p] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            K_APPEND: begin
                if (list_len < LIST_CAPACITY) begin
                    list_mem[list_len] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            K_REMOVE: begin
                if (p < list_len) begin
                    for (n = p; n + 1 < list_len; n++)
                        list_mem[n] = list_mem[n+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                for (n = 0; n < list_len; n++) begin
                    if (list_mem[n] == val) begin
                        r.found_index = n[OUT_IDX_W-1:0];
                        r.ok = 1'b1;
                    end
                end
            end
        endcase
        r.count = list_len[OUT_CNT_W-1:0];
        return r;
    endfunction

    function automatic void plan_req(t_kind kind, int pos, logic signed [DATA_W-1:0] val);
        t_list_req r;
        r = '0;
        r.kind = kind;
        r.pos = pos[POS_W-1:0];
        r.val = val;
        r.send_pct = send_idle_pct;
        r.recv_pct = recv_stall_pct;
        req_backlog.push_back(r);
        reqs_planned++;
        case (kind)
            K_INSERT: begin
                if (plan_vals.size() < LIST_CAPACITY && pos < plan_vals.size())
                    plan_vals.insert(pos, val);
            end
            K_APPEND: begin
                if (plan_vals.size() < LIST_CAPACITY)
                    plan_vals.push_back(val);
            end
            K_REMOVE: begin
                if (pos < plan_vals.size())
                    plan_vals.delete(pos);
            end
            default: ;
        endcase
    endfunction

    function automatic void plan_drain_pause();
        t_list_req r;
        r = '0;
        r.hold = 1'b1;
        req_backlog.push_back(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return int'($urandom_range(15)) - 8;
        endcase
    endfunction

    task automatic flag_reply(string what, t_list_reply want, t_list_reply got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected ok=%b index=%0d count=%0d, got ok=%b index=%0d count=%0d",
                     $realtime, what, want.ok, $signed(want.found_index), want.count,
                     got.ok, $signed(got.found_index), got.count);
    endtask

    always @(negedge i_clk) begin
        t_list_req nxt;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (req_backlog.size() != 0 && req_backlog[0].hold) begin
                if (due_replies.size() == 0)
                    void'(req_backlog.pop_front());
                i_valid <= 1'b0;
            end else if (req_backlog.size() != 0
                         && $urandom_range(99) >= req_backlog[0].send_pct) begin
                nxt = req_backlog.pop_front();
                i_valid <= 1'b1;
                i_kind <= nxt.kind;
                i_position <= nxt.pos;
                i_value <= nxt.val;
                recv_stall_pct = nxt.recv_pct;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_list_reply got;
        t_list_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_ok, o_found_index, o_count};
            if (due_replies.size() == 0) begin
                flag_reply("reply with no request pending", 'x, got);
            end else begin
                want = due_replies.pop_front();
                if (got.ok !== want.ok || got.found_index !== want.found_index
                    || got.count !== want.count)
                    flag_reply("reply mismatch", want, got);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            due_replies.push_back(apply_list_op(t_kind'(i_kind), i_position, i_value));
            reqs_accepted++;
        end
        req_taken <= i_rst_n && i_valid && o_ready;
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int k;
        int len;
        int pos;
        int roll;
        t_kind kind;
        t_trend trend;
        logic signed [DATA_W-1:0] val;

        plan_req(K_INSERT, 0, 32'sd11);
        plan_req(K_REMOVE, 0, 32'sd0);
        plan_req(K_SEARCH, 0, 32'sd0);
        plan_req(K_APPEND, 0, 32'sh7FFF_FFFF);
        plan_req(K_APPEND, 31, 32'sh8000_0000);
        plan_req(K_APPEND, 0, 32'sd0);
        plan_req(K_APPEND, 0, -32'sd1);
        plan_req(K_SEARCH, 0, -32'sd1);
        plan_req(K_INSERT, 0, 32'sh5555_5555);
        plan_req(K_INSERT, plan_vals.size() - 1, 32'shAAAA_AAAA);
        plan_req(K_INSERT, plan_vals.size(), 32'sd1);
        plan_req(K_INSERT, 31, 32'sd2);
        plan_req(K_APPEND, 0, 32'sd7);
        plan_req(K_APPEND, 0, 32'sd7);
        plan_req(K_SEARCH, 0, 32'sd7);
        plan_req(K_SEARCH, 0, 32'sh1234_5678);
        plan_req(K_REMOVE, 31, 32'sd0);
        plan_req(K_REMOVE, 0, 32'sd0);
        plan_req(K_REMOVE, plan_vals.size() - 1, 32'sd0);
        plan_req(K_REMOVE, 2, 32'sd0);
        plan_req(K_SEARCH, 0, 32'sh8000_0000);
        plan_drain_pause();

        trend = TREND_GROW;
        for (k = 0; k < RAND_REQS; k++) begin
            if (k % 100 == 0) begin
                case ((k / 100) % 4)
                    0: begin
                        send_idle_pct = 0;
                        recv_stall_pct = 0;
                    end
                    1: begin
                        send_idle_pct = 63;
                        recv_stall_pct = 0;
                    end
                    2: begin
                        send_idle_pct = 0;
                        recv_stall_pct = 63;
                    end
                    default: begin
                        send_idle_pct = 12;
                        recv_stall_pct = 12;
                    end
                endcase
            end
            if (k % 400 == 200)
                plan_drain_pause();
            len = plan_vals.size();
            case (trend)
                TREND_GROW: begin
                    if (len == LIST_CAPACITY && $urandom_range(7) == 0)
                        trend = TREND_SHRINK;
                end
                TREND_SHRINK: begin
                    if (len == 0 && $urandom_range(7) == 0)
                        trend = $urandom_range(1) ? TREND_GROW : TREND_MIX;
                end
                default: begin
                    if ($urandom_range(39) == 0)
                        trend = $urandom_range(1) ? TREND_GROW : TREND_SHRINK;
                end
            endcase
            roll = $urandom_range(99);
            case (trend)
                TREND_GROW:
                    kind = roll < 40 ? K_APPEND : roll < 75 ? K_INSERT
                         : roll < 85 ? K_REMOVE : K_SEARCH;
                TREND_SHRINK:
                    kind = roll < 10 ? K_APPEND : roll < 20 ? K_INSERT
                         : roll < 80 ? K_REMOVE : K_SEARCH;
                default:
                    kind = roll < 25 ? K_APPEND : roll < 50 ? K_INSERT
                         : roll < 75 ? K_REMOVE : K_SEARCH;
            endcase
            if (len > 0 && $urandom_range(5) != 0)
                pos = $urandom_range(len - 1);
            else
                pos = $urandom_range(31);
            if (kind == K_SEARCH && len > 0 && $urandom_range(2) != 0)
                val = plan_vals[$urandom_range(len - 1)];
            else
                val = pick_value();
            plan_req(kind, pos, val);
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((reqs_accepted < reqs_planned || due_replies.size() != 0)
               && quiet_cycles < QUIET_LIMIT)
            @(negedge i_clk);
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (8) @(negedge i_clk);
            if (mismatches == 0 && due_replies.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sal_pkg.sv
hw/rtl/sal_cell.sv
hw/rtl/shifting_array_list_top.sv
verif/tb_shifting_array_list_top.sv
